>>> sv/banked_boolean_stack_top_assert.svh
// ----------------------------------------------------------------------------
// Banked boolean stack assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BANKED_BOOLEAN_STACK_TOP_ASSERT_SVH
`define BANKED_BOOLEAN_STACK_TOP_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define BBS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define BBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define BBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/bbs_pkg.sv
// ----------------------------------------------------------------------------
// bbs_pkg
// Operation and status codes, widths and control types of the banked stack.
// ----------------------------------------------------------------------------
`default_nettype none

package bbs_pkg;

    localparam int OP_W        = 4;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_W     = 6;
    localparam int BANK_OUT_W  = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int EXTRA_BANKS_DEF = 7;

    localparam logic [OP_W-1:0] OP_CLEAR = 4'd0;
    localparam logic [OP_W-1:0] OP_PUSH  = 4'd1;
    localparam logic [OP_W-1:0] OP_DUP   = 4'd2;
    localparam logic [OP_W-1:0] OP_SWAP  = 4'd3;
    localparam logic [OP_W-1:0] OP_AND   = 4'd4;
    localparam logic [OP_W-1:0] OP_OR    = 4'd5;
    localparam logic [OP_W-1:0] OP_XOR   = 4'd6;
    localparam logic [OP_W-1:0] OP_OVER  = 4'd7;
    localparam logic [OP_W-1:0] OP_POP   = 4'd8;
    localparam logic [OP_W-1:0] OP_NOT   = 4'd9;
    localparam logic [OP_W-1:0] OP_NEXT  = 4'd10;
    localparam logic [OP_W-1:0] OP_PREV  = 4'd11;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FEW     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_NEXT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_PREV = 3'd5;

    typedef struct packed {
        logic load;
        logic exec;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic switch_go;
    } stat_t;

endpackage

`default_nettype wire

>>> sv/bbs_datapath.sv
// ----------------------------------------------------------------------------
// bbs_datapath
// Bank memory, bank counts, current bank and the operation logic of one step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "banked_boolean_stack_top_assert.svh"

module bbs_datapath #(
    parameter int STACK_DEPTH = 64,
    parameter int EXTRA_BANKS = 7
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire bbs_pkg::cmd_t              cmd,
    output bbs_pkg::stat_t                  stat,
    input  wire [bbs_pkg::OP_W-1:0]         op,
    input  wire                             push_value,
    output logic [bbs_pkg::STATUS_W-1:0]    status,
    output logic                            bit_out,
    output logic [bbs_pkg::DEPTH_W-1:0]     depth,
    output logic [bbs_pkg::BANK_OUT_W-1:0]  bank
);
    import bbs_pkg::*;

    localparam int NBANKS = EXTRA_BANKS + 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH);
    localparam int BANK_W = $clog2(NBANKS);

    logic [STACK_DEPTH-1:0] mem [NBANKS];
    logic [CNT_W-1:0]       counts_reg [NBANKS];
    logic [BANK_W-1:0]      bank_reg;
    logic [OP_W-1:0]        op_reg;
    logic                   pv_reg;
    logic [STACK_DEPTH-1:0] word_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic                   bit_reg;
    logic [DEPTH_W-1:0]     depth_reg;
    logic [BANK_OUT_W-1:0]  bank_out_reg;

    logic [CNT_W-1:0]       idx_m1;
    logic [CNT_W-1:0]       idx_m2;
    logic                   a_bit;
    logic                   b_bit;
    logic                   can_grow;
    logic                   has_one;
    logic                   has_two;
    logic                   logic_res;
    logic [STACK_DEPTH-1:0] res_word;
    logic [CNT_W-1:0]       res_cnt;
    logic [STATUS_W-1:0]    res_status;
    logic                   res_bit;
    logic                   res_write;
    logic                   sw_ok;
    logic [BANK_W-1:0]      res_bank;
    logic [BANK_W+BANK_OUT_W-1:0] bank_wide;

    assign idx_m1   = cnt_reg - CNT_W'(1);
    assign idx_m2   = cnt_reg - CNT_W'(2);
    assign has_one  = (cnt_reg != '0);
    assign has_two  = (cnt_reg >= CNT_W'(2)) && (CNT_W > 1);
    assign a_bit    = has_one ? word_reg[idx_m1] : 1'b0;
    assign b_bit    = has_two ? word_reg[idx_m2] : 1'b0;
    assign can_grow = (({1'b0, cnt_reg} + (CNT_W+1)'(1)) < (CNT_W+1)'(STACK_DEPTH));

    always_comb
    begin
        res_word   = word_reg;
        res_cnt    = cnt_reg;
        res_status = ST_OK;
        res_bit    = a_bit;
        sw_ok      = 1'b0;
        res_bank   = bank_reg;
        logic_res  = 1'b0;
        case (op_reg)
            OP_CLEAR:
            begin
                res_cnt = '0;
                res_bit = 1'b0;
            end
            OP_PUSH:
            begin
                if (!can_grow)
                begin
                    res_status = ST_OVER;
                end
                else
                begin
                    res_word[cnt_reg] = pv_reg;
                    res_cnt           = cnt_reg + CNT_W'(1);
                    res_bit           = pv_reg;
                end
            end
            OP_DUP:
            begin
                if (!has_one)
                begin
                    res_status = ST_EMPTY;
                end
                else if (!can_grow)
                begin
                    res_status = ST_OVER;
                end
                else
                begin
                    res_word[cnt_reg] = a_bit;
                    res_cnt           = cnt_reg + CNT_W'(1);
                end
            end
            OP_SWAP:
            begin
                if (!has_two)
                begin
                    res_status = ST_FEW;
                end
                else
                begin
                    res_word[idx_m1] = b_bit;
                    res_word[idx_m2] = a_bit;
                    res_bit          = b_bit;
                end
            end
            OP_AND, OP_OR, OP_XOR:
            begin
                if (op_reg == OP_AND)
                begin
                    logic_res = a_bit & b_bit;
                end
                else if (op_reg == OP_OR)
                begin
                    logic_res = a_bit | b_bit;
                end
                else
                begin
                    logic_res = a_bit ^ b_bit;
                end
                if (!has_two)
                begin
                    res_status = ST_FEW;
                end
                else
                begin
                    res_word[idx_m2] = logic_res;
                    res_cnt          = idx_m1;
                    res_bit          = logic_res;
                end
            end
            OP_OVER:
            begin
                if (!has_two)
                begin
                    res_status = ST_FEW;
                end
                else if (!can_grow)
                begin
                    res_status = ST_OVER;
                end
                else
                begin
                    res_word[cnt_reg] = b_bit;
                    res_cnt           = cnt_reg + CNT_W'(1);
                    res_bit           = b_bit;
                end
            end
            OP_POP:
            begin
                if (!has_one)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_cnt = idx_m1;
                end
            end
            OP_NOT:
            begin
                if (!has_one)
                begin
                    res_status = ST_EMPTY;
                end
                else
                begin
                    res_word[idx_m1] = ~a_bit;
                    res_bit          = ~a_bit;
                end
            end
            OP_NEXT:
            begin
                if (bank_reg >= BANK_W'(EXTRA_BANKS))
                begin
                    res_status = ST_NO_NEXT;
                end
                else
                begin
                    sw_ok    = 1'b1;
                    res_bank = bank_reg + BANK_W'(1);
                end
            end
            OP_PREV:
            begin
                if (bank_reg == '0)
                begin
                    res_status = ST_NO_PREV;
                end
                else
                begin
                    sw_ok    = 1'b1;
                    res_bank = bank_reg - BANK_W'(1);
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    assign res_write      = (res_status == ST_OK) && (op_reg <= OP_NOT);
    assign stat.switch_go = sw_ok;
    assign bank_wide      = (BANK_W+BANK_OUT_W)'(bank_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.exec && res_write)
        begin
            mem[bank_reg] <= res_word;
        end
        if (cmd.load)
        begin
            op_reg   <= op;
            pv_reg   <= push_value;
            word_reg <= mem[bank_reg];
        end
        else if (cmd.exec && sw_ok)
        begin
            word_reg <= mem[res_bank];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NBANKS; i++)
            begin
                counts_reg[i] <= '0;
            end
            bank_reg <= '0;
        end
        else
        begin
            if (cmd.exec && res_write)
            begin
                counts_reg[bank_reg] <= res_cnt;
            end
            if (cmd.exec && sw_ok)
            begin
                bank_reg <= res_bank;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cnt_reg <= counts_reg[bank_reg];
        end
        else if (cmd.exec && sw_ok)
        begin
            cnt_reg <= counts_reg[res_bank];
        end
        if (cmd.exec && !sw_ok)
        begin
            status_reg   <= res_status;
            bit_reg      <= (op_reg == OP_POP) ? a_bit : (res_write ? res_bit : a_bit);
            depth_reg    <= DEPTH_W'(res_write ? res_cnt : cnt_reg);
            bank_out_reg <= bank_wide[BANK_OUT_W-1:0];
        end
        else if (cmd.fin)
        begin
            status_reg   <= ST_OK;
            bit_reg      <= a_bit;
            depth_reg    <= DEPTH_W'(cnt_reg);
            bank_out_reg <= bank_wide[BANK_OUT_W-1:0];
        end
    end

    assign status  = status_reg;
    assign bit_out = bit_reg;
    assign depth   = depth_reg;
    assign bank    = bank_out_reg;

    `BBS_ASSERT_ALWAYS(a_bank_range, bank_reg <= BANK_W'(EXTRA_BANKS), "bank index out of range")
    `BBS_ASSERT_SAME(a_switch_no_write, cmd.exec && sw_ok, !res_write, "bank switch writes a bank")

endmodule

`default_nettype wire

>>> sv/bbs_ctrl.sv
// ----------------------------------------------------------------------------
// bbs_ctrl
// Sequencer for the stack: accept, execute, optional bank reload, result word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "banked_boolean_stack_top_assert.svh"

module bbs_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire             m_tready,
    output bbs_pkg::cmd_t   cmd,
    input  wire bbs_pkg::stat_t stat
);
    import bbs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       out_set;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.exec = (state_reg == S_EXEC) && out_free;
    assign cmd.fin  = (state_reg == S_FIN) && out_free;
    assign out_set  = (cmd.exec && !stat.switch_go) || cmd.fin;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next = stat.switch_go ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if (cmd.fin)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_set)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    `BBS_ASSERT_NEXT(a_accept_exec, cmd.load, state_reg == S_EXEC, "accept did not start execution")
    `BBS_ASSERT_SAME(a_no_overwrite, out_set, !out_valid_reg || m_tready, "result word overwritten")
    `BBS_ASSERT_NEXT(a_switch_fin, cmd.exec && stat.switch_go, state_reg == S_FIN,
        "bank switch did not reload")

endmodule

`default_nettype wire

>>> sv/banked_boolean_stack_top.sv
// Execute registers the result word; after a bank switch the reload step registers it.
// A new word is taken only after the registered bank memory read and the compute-and-write
// step of the last one, and its reload after a successful bank switch; both wait on a full output.
// A new word is taken while the previous result still waits at the output register.
// Reset clears every bank count and selects bank 0; stored bits stay undefined until pushed.
// ----------------------------------------------------------------------------
// banked_boolean_stack_top
// Bit stack with several banks and logic operations, one result word per input word.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_boolean_stack_top #(
    parameter int STACK_DEPTH = bbs_pkg::STACK_DEPTH_DEF,
    parameter int EXTRA_BANKS = bbs_pkg::EXTRA_BANKS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // op [3:0], push_value [4], zero [7:5]
    input  wire [bbs_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // status [2:0], bit_out [3], depth [9:4], bank [12:10], zero [15:13]
    output logic [bbs_pkg::M_TDATA_W-1:0]    m_tdata
);
    import bbs_pkg::*;

    cmd_t                  cmd;
    stat_t                 stat;
    logic [STATUS_W-1:0]   status;
    logic                  bit_out;
    logic [DEPTH_W-1:0]    depth;
    logic [BANK_OUT_W-1:0] bank;

    bbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bbs_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .EXTRA_BANKS (EXTRA_BANKS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (s_tdata[OP_W-1:0]),
        .push_value (s_tdata[OP_W]),
        .status     (status),
        .bit_out    (bit_out),
        .depth      (depth),
        .bank       (bank)
    );

    assign m_tdata = {3'b000, bank, depth, bit_out, status};

endmodule

`default_nettype wire
